FILE: src/analog_moving_average_quality_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the analog moving average quality block
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ANALOG_MOVING_AVERAGE_QUALITY_TOP_MACROS_SVH
`define ANALOG_MOVING_AVERAGE_QUALITY_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define AMAQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("amaq check failed");
// next-cycle implication
`define AMAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("amaq check failed");
`else
`define AMAQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AMAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/amaq_pkg.sv
// ----------------------------------------------------------------------------
// amaq_pkg
// Shared types, constants and scoring helpers for the moving average block.
// ----------------------------------------------------------------------------
package amaq_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int CH_FIELD_W = 3;
	localparam int SCORE_W    = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int MASK_W     = 8;

	localparam int DEF_CHANNELS     = 8;
	localparam int DEF_FILTER_DEPTH = 8;

	// overall mean: up to 8 scores of at most 100
	localparam int QSUM_W  = 10;
	localparam int QCNT_W  = 4;
	localparam int QRCP_W  = 11;
	localparam int QSHIFT  = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE       = 1'b0,
		REG_CHANNEL_ENABLE_MASK = 1'b1
	} cfg_reg_t;

	localparam logic [SCORE_W-1:0] Q_BEST  = 7'd100;
	localparam logic [SCORE_W-1:0] Q_GOOD  = 7'd95;
	localparam logic [SCORE_W-1:0] Q_FAIR  = 7'd90;
	localparam logic [SCORE_W-1:0] Q_POOR  = 7'd80;
	localparam logic [SCORE_W-1:0] Q_WORST = 7'd70;

	localparam logic [16:0] THR_BEST = 17'd10;
	localparam logic [16:0] THR_GOOD = 17'd50;
	localparam logic [16:0] THR_FAIR = 17'd100;
	localparam logic [16:0] THR_POOR = 17'd500;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_MUL,
		S_FIX,
		S_SCORE,
		S_QSUM,
		S_QMUL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                    wr;
		logic [CH_FIELD_W-1:0]   ch;
		logic [SCORE_W-1:0]      score;
		logic                    sum_en;
		logic                    mul_en;
	} qual_ctrl_t;

	// score from the change between two outputs, taken at 17 bits
	function automatic logic [SCORE_W-1:0] score_of(input logic signed [SAMPLE_W-1:0] cur,
		input logic signed [SAMPLE_W-1:0] prev);
		logic signed [SAMPLE_W:0] d;
		logic [SAMPLE_W:0] mag;
		logic [SCORE_W-1:0] s;
		d = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
		mag = d[SAMPLE_W] ? (SAMPLE_W+1)'(-d) : (SAMPLE_W+1)'(d);
		if (mag < THR_BEST)
			s = Q_BEST;
		else if (mag < THR_GOOD)
			s = Q_GOOD;
		else if (mag < THR_FAIR)
			s = Q_FAIR;
		else if (mag < THR_POOR)
			s = Q_POOR;
		else
			s = Q_WORST;
		return s;
	endfunction

	// floor(1024 / n) for the score mean
	function automatic logic [QRCP_W-1:0] qual_recip(input logic [QCNT_W-1:0] n);
		logic [QRCP_W-1:0] r;
		case (n)
			4'd1: r = 11'd1024;
			4'd2: r = 11'd512;
			4'd3: r = 11'd341;
			4'd4: r = 11'd256;
			4'd5: r = 11'd204;
			4'd6: r = 11'd170;
			4'd7: r = 11'd146;
			4'd8: r = 11'd128;
			default: r = 11'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/amaq_if.sv
// ----------------------------------------------------------------------------
// amaq interfaces
// Valid/ready channels for samples in and filtered results out.
// ----------------------------------------------------------------------------
interface amaq_in_if;
	logic                                       valid;
	logic                                       ready;
	logic [amaq_pkg::CH_FIELD_W-1:0]            channel;
	logic signed [amaq_pkg::SAMPLE_W-1:0]       raw_sample;
	logic                                       frame_end;

	modport source (output valid, output channel, output raw_sample, output frame_end,
		input ready);
	modport sink (input valid, input channel, input raw_sample, input frame_end,
		output ready);
endinterface

interface amaq_out_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [amaq_pkg::SAMPLE_W-1:0]       filtered_value;
	logic [amaq_pkg::SCORE_W-1:0]               channel_quality;
	logic [amaq_pkg::SCORE_W-1:0]               overall_quality;
	logic                                       frame_done;

	modport source (output valid, output filtered_value, output channel_quality,
		output overall_quality, output frame_done, input ready);
	modport sink (input valid, input filtered_value, input channel_quality,
		input overall_quality, input frame_done, output ready);
endinterface

FILE: src/amaq_ring_ram.sv
// ----------------------------------------------------------------------------
// amaq_ring_ram
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module amaq_ring_ram #(
	parameter int ADDR_W = 6
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [ADDR_W-1:0]                     waddr,
	input  logic signed [amaq_pkg::SAMPLE_W-1:0]  wdata,
	input  logic                                  re,
	input  logic [ADDR_W-1:0]                     raddr,
	output logic signed [amaq_pkg::SAMPLE_W-1:0]  rdata
);

	logic signed [amaq_pkg::SAMPLE_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: src/amaq_quality.sv
// ----------------------------------------------------------------------------
// amaq_quality
// Per-channel stored scores and the frame-end mean over enabled channels.
// ----------------------------------------------------------------------------
module amaq_quality #(
	parameter int CHANNELS = amaq_pkg::DEF_CHANNELS,
	parameter int CH_W     = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  amaq_pkg::qual_ctrl_t              ctrl,
	input  logic [amaq_pkg::MASK_W-1:0]       mask,
	output logic [amaq_pkg::SCORE_W-1:0]      overall
);

	logic [amaq_pkg::SCORE_W-1:0]  stored_q [CHANNELS];
	logic [amaq_pkg::QSUM_W-1:0]   qsum_q;
	logic [amaq_pkg::QCNT_W-1:0]   qcnt_q;
	logic [amaq_pkg::QSUM_W+amaq_pkg::QRCP_W-1:0] qprod_q;

	logic [amaq_pkg::QSUM_W-1:0]   sum_d;
	logic [amaq_pkg::QCNT_W-1:0]   cnt_d;
	logic [amaq_pkg::QRCP_W-1:0]   q0;
	logic [amaq_pkg::QRCP_W-1:0]   qn;
	logic [amaq_pkg::QRCP_W-1:0]   rem;
	logic [amaq_pkg::QRCP_W-1:0]   qfix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++)
				stored_q[c] <= amaq_pkg::Q_BEST;
		end else if (ctrl.wr) begin
			stored_q[ctrl.ch[CH_W-1:0]] <= ctrl.score;
		end
	end

	always_comb begin
		sum_d = '0;
		cnt_d = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (mask[c]) begin
				sum_d = sum_d + amaq_pkg::QSUM_W'(stored_q[c]);
				cnt_d = cnt_d + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_en) begin
			qsum_q <= sum_d;
			qcnt_q <= cnt_d;
		end
		if (ctrl.mul_en)
			qprod_q <= (amaq_pkg::QSUM_W+amaq_pkg::QRCP_W)'(qsum_q)
				* (amaq_pkg::QSUM_W+amaq_pkg::QRCP_W)'(amaq_pkg::qual_recip(qcnt_q));
	end

	// reciprocal estimate is at most one low: fix it with the remainder
	always_comb begin
		q0   = qprod_q[amaq_pkg::QSHIFT +: amaq_pkg::QRCP_W];
		qn   = amaq_pkg::QRCP_W'(q0 * amaq_pkg::QRCP_W'(qcnt_q));
		rem  = amaq_pkg::QRCP_W'(qsum_q) - qn;
		qfix = (rem >= amaq_pkg::QRCP_W'(qcnt_q)) ? q0 + 1'b1 : q0;
		if (qcnt_q == '0)
			overall = amaq_pkg::Q_BEST;
		else
			overall = qfix[amaq_pkg::SCORE_W-1:0];
	end

endmodule

FILE: src/analog_moving_average_quality_top.sv
// ----------------------------------------------------------------------------
// analog_moving_average_quality_top
// Multichannel moving average with per-channel quality scoring.
// ----------------------------------------------------------------------------
// The sequencer steps each accepted sample through the ring read,
// running-sum update, reciprocal multiply, remainder correction and
// scoring, plus two steps for the score mean when frame_end is set, and
// then waits in its done state until the output register is free before
// it is ready again. The ring lives in one synchronous RAM of
// 2^CH_W x 2^ceil(log2(FILTER_DEPTH)) words; per-channel running sums and
// a ring-full flag stand in for clearing it, so the block is ready at once
// after reset. A finished result waits in the output register while the
// next sample is taken.
// ----------------------------------------------------------------------------
`include "analog_moving_average_quality_top_macros.svh"

module analog_moving_average_quality_top #(
	parameter int CHANNELS     = amaq_pkg::DEF_CHANNELS,
	parameter int FILTER_DEPTH = amaq_pkg::DEF_FILTER_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	amaq_in_if.sink                              sample_in,
	amaq_out_if.source                           result_out,
	input  logic                                 cfg_we,
	input  logic [amaq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [amaq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int SW     = amaq_pkg::SAMPLE_W;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW     = $clog2(FILTER_DEPTH);
	localparam int ADDR_W = CH_W + PW;
	localparam int SUM_W  = SW + PW;
	localparam logic [SUM_W-1:0] DEPTH_C = SUM_W'(FILTER_DEPTH);
	localparam logic [SUM_W-1:0] RECIP_C = SUM_W'((2**SUM_W) / FILTER_DEPTH);
	localparam logic [PW-1:0]    LAST_POS = PW'(FILTER_DEPTH - 1);

	amaq_pkg::state_t state_q, state_d;

	logic                                 filter_en_q;
	logic [amaq_pkg::MASK_W-1:0]          mask_q;

	logic [PW-1:0]                        pos_q  [CHANNELS];
	logic                                 full_q [CHANNELS];
	logic signed [SUM_W-1:0]              rsum_q [CHANNELS];
	logic signed [SW-1:0]                 prev_q [CHANNELS];

	logic [amaq_pkg::CH_FIELD_W-1:0]      ch_q;
	logic                                 ch_ok_q;
	logic signed [SW-1:0]                 raw_q;
	logic                                 fe_q;
	logic [ADDR_W-1:0]                    addr_q;

	logic signed [SUM_W-1:0]              sum_q;
	logic                                 neg_q;
	logic [SUM_W-1:0]                     mag_q;
	logic [2*SUM_W-1:0]                   prod_q;
	logic signed [SW-1:0]                 value_q;
	logic [amaq_pkg::SCORE_W-1:0]         score_q;

	logic                                 out_valid_q;
	logic signed [SW-1:0]                 out_value_q;
	logic [amaq_pkg::SCORE_W-1:0]         out_score_q;
	logic [amaq_pkg::SCORE_W-1:0]         out_overall_q;
	logic                                 out_fd_q;

	logic                                 accept;
	logic                                 done_fire;
	logic                                 filt_active;
	logic [CH_W-1:0]                      in_ci;
	logic [CH_W-1:0]                      ci;
	logic [ADDR_W-1:0]                    rd_addr;
	logic signed [SW-1:0]                 rd_data;
	logic signed [SW-1:0]                 old_sample;
	logic signed [SUM_W-1:0]              new_sum;
	logic [SUM_W-1:0]                     mag_d;
	logic [SUM_W-1:0]                     q0;
	logic [SUM_W-1:0]                     rem;
	logic [SUM_W-1:0]                     qfix;
	logic [SW-1:0]                        q16;
	logic signed [SW-1:0]                 avg;
	logic [amaq_pkg::SCORE_W-1:0]         score_d;
	logic [amaq_pkg::SCORE_W-1:0]         overall;
	amaq_pkg::qual_ctrl_t                 qctrl;

	assign accept      = sample_in.valid && sample_in.ready;
	assign done_fire   = (state_q == amaq_pkg::S_DONE) && (!out_valid_q || result_out.ready);
	assign filt_active = filter_en_q && ch_ok_q;
	assign in_ci       = sample_in.channel[CH_W-1:0];
	assign ci          = ch_q[CH_W-1:0];
	assign rd_addr     = {in_ci, pos_q[in_ci]};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b1;
			mask_q      <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				amaq_pkg::REG_FILTER_ENABLE:       filter_en_q <= cfg_wdata[0];
				amaq_pkg::REG_CHANNEL_ENABLE_MASK: mask_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= amaq_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		sample_in.ready = 1'b0;
		case (state_q)
			amaq_pkg::S_IDLE: begin
				sample_in.ready = 1'b1;
				if (sample_in.valid)
					state_d = amaq_pkg::S_SUM;
			end
			amaq_pkg::S_SUM:   state_d = amaq_pkg::S_MUL;
			amaq_pkg::S_MUL:   state_d = amaq_pkg::S_FIX;
			amaq_pkg::S_FIX:   state_d = amaq_pkg::S_SCORE;
			amaq_pkg::S_SCORE: state_d = fe_q ? amaq_pkg::S_QSUM : amaq_pkg::S_DONE;
			amaq_pkg::S_QSUM:  state_d = amaq_pkg::S_QMUL;
			amaq_pkg::S_QMUL:  state_d = amaq_pkg::S_DONE;
			amaq_pkg::S_DONE: begin
				if (!out_valid_q || result_out.ready)
					state_d = amaq_pkg::S_IDLE;
			end
			default: state_d = amaq_pkg::S_IDLE;
		endcase
	end

	// capture the beat
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= sample_in.channel;
			ch_ok_q <= ((amaq_pkg::CH_FIELD_W+1)'(sample_in.channel)
				< (amaq_pkg::CH_FIELD_W+1)'(CHANNELS));
			raw_q   <= sample_in.raw_sample;
			fe_q    <= sample_in.frame_end;
			addr_q  <= rd_addr;
		end
	end

	amaq_ring_ram #(
		.ADDR_W (ADDR_W)
	) u_ring (
		.clk   (clk),
		.we    ((state_q == amaq_pkg::S_SUM) && filt_active),
		.waddr (addr_q),
		.wdata (raw_q),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// slot never written before reads as zero
	assign old_sample = full_q[ci] ? rd_data : '0;
	assign new_sum = rsum_q[ci] - {{PW{old_sample[SW-1]}}, old_sample}
		+ {{PW{raw_q[SW-1]}}, raw_q};

	// per-channel ring bookkeeping and previous output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c]  <= '0;
				full_q[c] <= 1'b0;
				rsum_q[c] <= '0;
				prev_q[c] <= '0;
			end
		end else begin
			if ((state_q == amaq_pkg::S_SUM) && filt_active) begin
				rsum_q[ci] <= new_sum;
				if (pos_q[ci] == LAST_POS) begin
					pos_q[ci]  <= '0;
					full_q[ci] <= 1'b1;
				end else begin
					pos_q[ci] <= pos_q[ci] + 1'b1;
				end
			end
			if ((state_q == amaq_pkg::S_SCORE) && ch_ok_q)
				prev_q[ci] <= value_q;
		end
	end

	// divide by depth: reciprocal multiply, then one correction step
	assign mag_d = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	always_comb begin
		q0   = prod_q[SUM_W +: SUM_W];
		rem  = mag_q - SUM_W'(q0 * DEPTH_C);
		qfix = (rem >= DEPTH_C) ? q0 + 1'b1 : q0;
		q16  = qfix[SW-1:0];
		avg  = neg_q ? SW'(-q16) : SW'(q16);
	end

	assign score_d = ch_ok_q ? amaq_pkg::score_of(value_q, prev_q[ci]) : amaq_pkg::Q_BEST;

	always_ff @(posedge clk) begin
		if (state_q == amaq_pkg::S_SUM)
			sum_q <= new_sum;
		if (state_q == amaq_pkg::S_MUL) begin
			neg_q  <= sum_q[SUM_W-1];
			mag_q  <= mag_d;
			prod_q <= (2*SUM_W)'(mag_d) * (2*SUM_W)'(RECIP_C);
		end
		if (state_q == amaq_pkg::S_FIX)
			value_q <= filt_active ? avg : raw_q;
		if (state_q == amaq_pkg::S_SCORE)
			score_q <= score_d;
	end

	always_comb begin
		qctrl.wr     = (state_q == amaq_pkg::S_SCORE) && ch_ok_q;
		qctrl.ch     = ch_q;
		qctrl.score  = score_d;
		qctrl.sum_en = (state_q == amaq_pkg::S_QSUM);
		qctrl.mul_en = (state_q == amaq_pkg::S_QMUL);
	end

	amaq_quality #(
		.CHANNELS (CHANNELS),
		.CH_W     (CH_W)
	) u_quality (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (qctrl),
		.mask    (mask_q),
		.overall (overall)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_fire)
			out_valid_q <= 1'b1;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_value_q   <= value_q;
			out_score_q   <= score_q;
			out_overall_q <= fe_q ? overall : '0;
			out_fd_q      <= fe_q;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.filtered_value  = out_value_q;
	assign result_out.channel_quality = out_score_q;
	assign result_out.overall_quality = out_overall_q;
	assign result_out.frame_done      = out_fd_q;

	`AMAQ_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == amaq_pkg::S_SUM)
	`AMAQ_ASSERT_NEXT(a_done_loads, clk, arst_n, done_fire, out_valid_q && state_q == amaq_pkg::S_IDLE)
	`AMAQ_ASSERT_SAME(a_overall_idle, clk, arst_n, result_out.valid && !result_out.frame_done, result_out.overall_quality == '0)
	`AMAQ_ASSERT_SAME(a_score_range, clk, arst_n, result_out.valid, result_out.channel_quality >= amaq_pkg::Q_WORST && result_out.channel_quality <= amaq_pkg::Q_BEST)

endmodule
